>>> rtl/core/msa_pkg.sv
// Package for the magnetometer sample averager core.
// Holds the port widths, status codes, register indexes and fixed constants.
// No dependencies.
package msa_pkg;

    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 56;
    localparam int M_TUSER_W   = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int WORD_W  = 16;
    localparam int COUNT_W = 4;
    localparam int TIME_W  = 32;
    localparam int PROD_W  = 33;
    localparam int DIV_BITS = 17;
    localparam int DIV_CNT_W = 5;

    typedef logic [M_TUSER_W-1:0] status_t;

    localparam status_t STAT_TAKEN      = 3'd0;
    localparam status_t STAT_SKIPPED    = 3'd1;
    localparam status_t STAT_BUS_ERROR  = 3'd2;
    localparam status_t STAT_MARKER     = 3'd3;
    localparam status_t STAT_READ_OK    = 3'd4;
    localparam status_t STAT_READ_EMPTY = 3'd5;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_SENSOR_ENABLED  = 3'd0;
    localparam cfg_index_t REG_AXIS_ORDER      = 3'd1;
    localparam cfg_index_t REG_MIN_INTERVAL_US = 3'd2;
    localparam cfg_index_t REG_GAIN_X          = 3'd3;
    localparam cfg_index_t REG_GAIN_Y          = 3'd4;
    localparam cfg_index_t REG_GAIN_Z          = 3'd5;

    localparam logic [WORD_W-1:0] MARKER_WORD      = 16'hF000;
    localparam logic [WORD_W-1:0] MIN_INTERVAL_RST = 16'd13333;
    localparam logic [WORD_W-1:0] GAIN_RST         = 16'd16384;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

>>> rtl/core/magnetometer_sample_averager_core.sv
// Magnetometer sample averager core: accumulates axis samples and returns
// gain-scaled averages through one shared multiplier and a restoring divider.
// Depends on msa_pkg.
// Steps: a read with samples held runs, per axis, one multiply, one load,
// 17 divider steps by the sample count and one saturate step; other beats
// go straight to the output. The 17-step divider is shared by the three
// axes, and a new beat is accepted only once the last result has moved to
// the output register, where it waits while the next beat is accepted.
// Reset is synchronous, active low: sums, count and sample time clear, the
// link is marked good, registers load their reset values.
module magnetometer_sample_averager_core #(
    parameter int HALVE_AT = 14
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [msa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [msa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, now_us
    input  logic [msa_pkg::S_TDATA_W-1:0]    s_tdata,
    // func, bus_error
    input  logic [msa_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // field_x, field_y, field_z, samples_used, zero padding
    output logic [msa_pkg::M_TDATA_W-1:0]    m_tdata,
    // status
    output logic [msa_pkg::M_TUSER_W-1:0]    m_tuser
);
    import msa_pkg::*;

    localparam logic [COUNT_W-1:0] HALVE_CNT = COUNT_W'(HALVE_AT);
    localparam logic [COUNT_W-1:0] HALF_CNT  = COUNT_W'(HALVE_AT / 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic              enabled_reg, enabled_next;
    logic              axis_order_reg, axis_order_next;
    logic [WORD_W-1:0] min_int_reg, min_int_next;
    logic [WORD_W-1:0] gain_x_reg, gain_x_next;
    logic [WORD_W-1:0] gain_y_reg, gain_y_next;
    logic [WORD_W-1:0] gain_z_reg, gain_z_next;

    logic [WORD_W-1:0]  sum_x_reg, sum_x_next;
    logic [WORD_W-1:0]  sum_y_reg, sum_y_next;
    logic [WORD_W-1:0]  sum_z_reg, sum_z_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    logic               link_good_reg, link_good_next;

    logic [S_TDATA_W-1:0] item_data_reg, item_data_next;
    logic [S_TUSER_W-1:0] item_user_reg, item_user_next;

    logic [1:0]                axis_reg, axis_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      neg_reg, neg_next;
    logic [DIV_BITS-1:0]       dq_reg, dq_next;
    logic [COUNT_W-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic [2:0][WORD_W-1:0]    res_reg, res_next;
    status_t                   pend_status_reg, pend_status_next;
    logic [COUNT_W-1:0]        pend_used_reg, pend_used_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t              m_tuser_reg, m_tuser_next;

    logic              it_func;
    logic              it_berr;
    logic [TIME_W-1:0] it_now;
    logic [WORD_W-1:0] wx, w2, w3, wy, wz;
    logic [WORD_W-1:0] acc_x, acc_y, acc_z;
    logic [COUNT_W-1:0] count_inc;
    logic [TIME_W-1:0] elapsed;
    logic              too_soon;
    logic              is_marker;
    logic [WORD_W-1:0] mul_sum, mul_gain;
    logic [PROD_W-1:0] prod_mag;
    logic [COUNT_W:0]  trial;
    logic              trial_ge;
    logic [WORD_W-1:0] sat_val;

    function automatic logic [WORD_W-1:0] halve16(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w + {{(WORD_W-1){1'b0}}, w[WORD_W-1]};
        return {t[WORD_W-1], t[WORD_W-1:1]};
    endfunction

    assign it_func = item_user_reg[0];
    assign it_berr = item_user_reg[1];
    assign it_now  = item_data_reg[79:48];
    assign wx = {item_data_reg[7:0], item_data_reg[15:8]};
    assign w2 = {item_data_reg[23:16], item_data_reg[31:24]};
    assign w3 = {item_data_reg[39:32], item_data_reg[47:40]};
    assign wy = axis_order_reg ? w3 : w2;
    assign wz = axis_order_reg ? w2 : w3;

    assign acc_x     = sum_x_reg - wx;
    assign acc_y     = sum_y_reg + wy;
    assign acc_z     = sum_z_reg - wz;
    assign count_inc = count_reg + COUNT_W'(1);
    assign elapsed   = it_now - last_time_reg;
    assign too_soon  = link_good_reg && (count_reg != '0) &&
                       (elapsed < {{(TIME_W-WORD_W){1'b0}}, min_int_reg});
    assign is_marker = (wx == MARKER_WORD) || (wy == MARKER_WORD) ||
                       (wz == MARKER_WORD);

    always_comb begin
        case (axis_reg)
            AXIS_X: begin
                mul_sum  = sum_x_reg;
                mul_gain = gain_x_reg;
            end
            AXIS_Y: begin
                mul_sum  = sum_y_reg;
                mul_gain = gain_y_reg;
            end
            default: begin
                mul_sum  = sum_z_reg;
                mul_gain = gain_z_reg;
            end
        endcase
    end

    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign trial    = {rem_reg, dq_reg[DIV_BITS-1]};
    assign trial_ge = trial >= {1'b0, count_reg};

    always_comb begin
        if (neg_reg) begin
            if (dq_reg >= DIV_BITS'(32768)) begin
                sat_val = 16'h8000;
            end else begin
                sat_val = WORD_W'(~dq_reg + DIV_BITS'(1));
            end
        end else begin
            if (dq_reg > DIV_BITS'(32767)) begin
                sat_val = 16'h7FFF;
            end else begin
                sat_val = dq_reg[WORD_W-1:0];
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        enabled_next     = enabled_reg;
        axis_order_next  = axis_order_reg;
        min_int_next     = min_int_reg;
        gain_x_next      = gain_x_reg;
        gain_y_next      = gain_y_reg;
        gain_z_next      = gain_z_reg;
        sum_x_next       = sum_x_reg;
        sum_y_next       = sum_y_reg;
        sum_z_next       = sum_z_reg;
        count_next       = count_reg;
        last_time_next   = last_time_reg;
        link_good_next   = link_good_reg;
        item_data_next   = item_data_reg;
        item_user_next   = item_user_reg;
        axis_next        = axis_reg;
        prod_next        = prod_reg;
        neg_next         = neg_reg;
        dq_next          = dq_reg;
        rem_next         = rem_reg;
        div_cnt_next     = div_cnt_reg;
        res_next         = res_reg;
        pend_status_next = pend_status_reg;
        pend_used_next   = pend_used_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SENSOR_ENABLED:  enabled_next    = cfg_wdata[0];
                REG_AXIS_ORDER:      axis_order_next = cfg_wdata[0];
                REG_MIN_INTERVAL_US: min_int_next    = cfg_wdata;
                REG_GAIN_X:          gain_x_next     = cfg_wdata;
                REG_GAIN_Y:          gain_y_next     = cfg_wdata;
                REG_GAIN_Z:          gain_z_next     = cfg_wdata;
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    item_data_next = s_tdata;
                    item_user_next = s_tuser;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next       = '0;
                pend_used_next = count_reg;
                state_next     = ST_OUT;
                if (!enabled_reg) begin
                    pend_status_next = STAT_SKIPPED;
                end else if (it_func) begin
                    if (count_reg == '0) begin
                        pend_status_next = STAT_READ_EMPTY;
                    end else begin
                        pend_status_next = STAT_READ_OK;
                        axis_next        = AXIS_X;
                        state_next       = ST_MUL;
                    end
                end else if (too_soon) begin
                    pend_status_next = STAT_SKIPPED;
                end else if (it_berr) begin
                    pend_status_next = STAT_BUS_ERROR;
                    link_good_next   = 1'b0;
                end else if (is_marker) begin
                    pend_status_next = STAT_MARKER;
                end else begin
                    pend_status_next = STAT_TAKEN;
                    last_time_next   = it_now;
                    if (count_inc >= HALVE_CNT) begin
                        sum_x_next     = halve16(acc_x);
                        sum_y_next     = halve16(acc_y);
                        sum_z_next     = halve16(acc_z);
                        count_next     = HALF_CNT;
                        pend_used_next = HALF_CNT;
                    end else begin
                        sum_x_next     = acc_x;
                        sum_y_next     = acc_y;
                        sum_z_next     = acc_z;
                        count_next     = count_inc;
                        pend_used_next = count_inc;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = $signed(mul_sum) * $signed({1'b0, mul_gain});
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                neg_next     = prod_reg[PROD_W-1];
                dq_next      = prod_mag[30:14];
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                rem_next     = trial_ge ? COUNT_W'(trial - {1'b0, count_reg})
                                        : trial[COUNT_W-1:0];
                dq_next      = {dq_reg[DIV_BITS-2:0], trial_ge};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_BITS - 1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                res_next[axis_reg] = sat_val;
                if (axis_reg == AXIS_Z) begin
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    sum_z_next     = '0;
                    count_next     = '0;
                    link_good_next = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W-3*WORD_W-COUNT_W){1'b0}},
                                     pend_used_reg, res_reg[2], res_reg[1], res_reg[0]};
                    m_tuser_next  = pend_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            enabled_reg    <= 1'b0;
            axis_order_reg <= 1'b0;
            min_int_reg    <= MIN_INTERVAL_RST;
            gain_x_reg     <= GAIN_RST;
            gain_y_reg     <= GAIN_RST;
            gain_z_reg     <= GAIN_RST;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            sum_z_reg      <= '0;
            count_reg      <= '0;
            last_time_reg  <= '0;
            link_good_reg  <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            enabled_reg    <= enabled_next;
            axis_order_reg <= axis_order_next;
            min_int_reg    <= min_int_next;
            gain_x_reg     <= gain_x_next;
            gain_y_reg     <= gain_y_next;
            gain_z_reg     <= gain_z_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            sum_z_reg      <= sum_z_next;
            count_reg      <= count_next;
            last_time_reg  <= last_time_next;
            link_good_reg  <= link_good_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        item_data_reg   <= item_data_next;
        item_user_reg   <= item_user_next;
        axis_reg        <= axis_next;
        prod_reg        <= prod_next;
        neg_reg         <= neg_next;
        dq_reg          <= dq_next;
        rem_reg         <= rem_next;
        div_cnt_reg     <= div_cnt_next;
        res_reg         <= res_next;
        pend_status_reg <= pend_status_next;
        pend_used_reg   <= pend_used_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_one_beat_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A second beat was accepted while one was in progress.");

    a_count_below_halving: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < HALVE_CNT)
        else $error("The sample count reached the halving threshold.");

    a_read_ok_has_samples: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_READ_OK)) |-> (m_tdata[51:48] != '0))
        else $error("A successful read reported no samples.");

    a_fields_zero_otherwise: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STAT_READ_OK)) |-> (m_tdata[47:0] == '0))
        else $error("Axis fields are non-zero on a result that is not a read.");

    a_read_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_STORE) && (axis_reg == AXIS_Z)) |=>
            ((count_reg == '0) && link_good_reg))
        else $error("A completed read did not clear the accumulated state.");

endmodule

>>> verif/magnetometer_sample_averager_core_tb.sv
// Testbench for magnetometer_sample_averager_core: directed and random sample and read beats,
// checked field by field against a behavioural model of the averager held in this file.
// Depends on msa_pkg and the core; needs no files or arguments.
`timescale 1ns / 100ps

module magnetometer_sample_averager_core_tb;
    import msa_pkg::*;

    localparam int HALVE_AT = 14;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_BEATS = 155;

    typedef struct packed {
        logic        func;
        logic        bus_error;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [31:0] now_us;
    } beat_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] field_x;
        logic [15:0] field_y;
        logic [15:0] field_z;
        logic [3:0]  samples_used;
    } result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    magnetometer_sample_averager_core #(
        .HALVE_AT(HALVE_AT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Model registers and state of the averager.
    logic        enabled_cfg;
    logic        swap_yz_cfg;
    logic [15:0] min_gap_cfg;
    logic [15:0] gain_x_cfg;
    logic [15:0] gain_y_cfg;
    logic [15:0] gain_z_cfg;
    logic [15:0] acc_x;
    logic [15:0] acc_y;
    logic [15:0] acc_z;
    logic [3:0]  held_count;
    logic [31:0] last_take_us;
    logic        link_ok;

    result_t expected_q[$];
    int      mismatch_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      quiet_cycles = 0;
    logic [31:0] stamp_us;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [15:0] halved(input logic [15:0] w);
        int v;
        v = int'($signed(w));
        return 16'(v / 2);
    endfunction

    function automatic logic [15:0] scaled_mean(input logic [15:0] s, input logic [15:0] g,
                                                input logic [3:0] n);
        longint p;
        longint q;
        p = longint'($signed(s)) * longint'(g);
        q = p / (longint'(n) * 16384);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic result_t average_step(input beat_t b);
        result_t     r;
        logic [15:0] wy;
        logic [15:0] wz;
        logic [31:0] elapsed;
        r = '0;
        r.samples_used = held_count;
        elapsed = b.now_us - last_take_us;
        wy = swap_yz_cfg ? b.word_c : b.word_b;
        wz = swap_yz_cfg ? b.word_b : b.word_c;
        if (!enabled_cfg) begin
            r.status = STAT_SKIPPED;
        end else if (b.func) begin
            if (held_count == 0) begin
                r.status = STAT_READ_EMPTY;
            end else begin
                r.status = STAT_READ_OK;
                r.field_x = scaled_mean(acc_x, gain_x_cfg, held_count);
                r.field_y = scaled_mean(acc_y, gain_y_cfg, held_count);
                r.field_z = scaled_mean(acc_z, gain_z_cfg, held_count);
                acc_x = '0;
                acc_y = '0;
                acc_z = '0;
                held_count = '0;
                link_ok = 1'b1;
            end
        end else if (link_ok && held_count != 0 && elapsed < {16'd0, min_gap_cfg}) begin
            r.status = STAT_SKIPPED;
        end else if (b.bus_error) begin
            link_ok = 1'b0;
            r.status = STAT_BUS_ERROR;
        end else if (b.word_a == MARKER_WORD || wy == MARKER_WORD || wz == MARKER_WORD) begin
            r.status = STAT_MARKER;
        end else begin
            acc_x = acc_x - b.word_a;
            acc_y = acc_y + wy;
            acc_z = acc_z - wz;
            held_count = held_count + 4'd1;
            if (held_count >= HALVE_AT) begin
                acc_x = halved(acc_x);
                acc_y = halved(acc_y);
                acc_z = halved(acc_z);
                held_count = 4'(HALVE_AT / 2);
            end
            last_take_us = b.now_us;
            r.status = STAT_TAKEN;
            r.samples_used = held_count;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (recv_stall_pct == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: status %0d", m_tuser);
                mismatch_count++;
            end else begin
                e = expected_q.pop_front();
                check_field("status", 16'(e.status), 16'(m_tuser));
                check_field("field_x", e.field_x, m_tdata[15:0]);
                check_field("field_y", e.field_y, m_tdata[31:16]);
                check_field("field_z", e.field_z, m_tdata[47:32]);
                check_field("samples_used", 16'(e.samples_used), 16'(m_tdata[51:48]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(input logic func, input logic bus_error, input logic [15:0] a,
                             input logic [15:0] b, input logic [15:0] c,
                             input logic [31:0] now);
        beat_t bt;
        bt = '{func, bus_error, a, b, c, now};
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {now, c[7:0], c[15:8], b[7:0], b[15:8], a[7:0], a[15:8]};
        s_tuser <= {bus_error, func};
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_q.push_back(average_step(bt));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_SENSOR_ENABLED:  enabled_cfg = value[0];
            REG_AXIS_ORDER:      swap_yz_cfg = value[0];
            REG_MIN_INTERVAL_US: min_gap_cfg = value;
            REG_GAIN_X:          gain_x_cfg = value;
            REG_GAIN_Y:          gain_y_cfg = value;
            REG_GAIN_Z:          gain_z_cfg = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
    endtask

    function automatic logic [15:0] pick_gain;
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return GAIN_RST;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_disabled;
        send_beat(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, stamp_us);
        send_beat(1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, stamp_us);
        drain();
    endtask

    task automatic test_special_cases;
        write_reg(REG_SENSOR_ENABLED, 16'd1);
        send_beat(1'b1, 1'b0, 16'h1234, 16'h5678, 16'h9ABC, stamp_us);
        send_beat(1'b0, 1'b0, 16'h8000, 16'h7FFF, 16'h0000, stamp_us);
        send_beat(1'b0, 1'b1, 16'h0001, 16'h0001, 16'h0001, stamp_us + 32'd1);
        stamp_us += 32'd13333;
        send_beat(1'b0, 1'b1, 16'h0002, 16'h0002, 16'h0002, stamp_us);
        // The link is down, so a beat arriving too soon is still taken.
        send_beat(1'b0, 1'b0, 16'hFFFF, 16'h0001, 16'hFFFE, stamp_us + 32'd1);
        stamp_us += 32'd20000;
        send_beat(1'b0, 1'b0, MARKER_WORD, 16'h0010, 16'h0020, stamp_us);
        drain();
        write_reg(REG_AXIS_ORDER, 16'd1);
        stamp_us += 32'd20000;
        send_beat(1'b0, 1'b0, 16'h0100, MARKER_WORD, 16'h0200, stamp_us);
        stamp_us += 32'd20000;
        send_beat(1'b0, 1'b0, 16'h0100, 16'h0200, MARKER_WORD, stamp_us);
        send_beat(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_halving;
        write_reg(REG_AXIS_ORDER, 16'd0);
        write_reg(REG_MIN_INTERVAL_US, 16'd0);
        write_reg(REG_GAIN_X, 16'hFFFF);
        write_reg(REG_GAIN_Y, 16'd0);
        write_reg(REG_GAIN_Z, 16'hFFFF);
        for (int i = 0; i < HALVE_AT; i++) begin
            send_beat(1'b0, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom), stamp_us);
        end
        send_beat(1'b1, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom), stamp_us);
        drain();
    endtask

    task automatic run_sequences(input int beats);
        int sent;
        int run_len;
        int roll;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [31:0] step;
        sent = 0;
        while (sent < beats) begin
            run_len = $urandom_range(0, 18);
            for (int i = 0; i < run_len && sent < beats; i++) begin
                roll = $urandom_range(99);
                a = 16'($urandom);
                b = 16'($urandom);
                c = 16'($urandom);
                step = {16'd0, min_gap_cfg} + $urandom_range(0, 2000);
                if (roll < 10 && min_gap_cfg != 0) begin
                    step = $urandom_range(0, min_gap_cfg - 1);
                end else if (roll < 14) begin
                    step = {16'd0, min_gap_cfg};
                end
                stamp_us += step;
                if (roll >= 14 && roll < 20) begin
                    case ($urandom_range(2))
                        0: a = MARKER_WORD;
                        1: b = MARKER_WORD;
                        default: c = MARKER_WORD;
                    endcase
                end
                send_beat(1'b0, roll >= 20 && roll < 26, a, b, c, stamp_us);
                sent++;
            end
            send_beat(1'b1, 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      $urandom);
            sent++;
        end
    endtask

    task automatic test_random_traffic;
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            set_idle(phase % 4);
            stamp_us = $urandom;
            case (phase)
                0: begin
                    write_reg(REG_SENSOR_ENABLED, 16'd1);
                    write_reg(REG_AXIS_ORDER, 16'd0);
                    write_reg(REG_MIN_INTERVAL_US, MIN_INTERVAL_RST);
                    write_reg(REG_GAIN_X, GAIN_RST);
                    write_reg(REG_GAIN_Y, GAIN_RST);
                    write_reg(REG_GAIN_Z, GAIN_RST);
                end
                1: begin
                    write_reg(REG_AXIS_ORDER, 16'd1);
                    write_reg(REG_MIN_INTERVAL_US, 16'd0);
                    write_reg(REG_GAIN_X, 16'hFFFF);
                    write_reg(REG_GAIN_Y, 16'd0);
                    write_reg(REG_GAIN_Z, 16'hFFFF);
                end
                2: begin
                    write_reg(REG_SENSOR_ENABLED, 16'd0);
                end
                3: begin
                    write_reg(REG_SENSOR_ENABLED, 16'd1);
                    write_reg(REG_MIN_INTERVAL_US, 16'hFFFF);
                    write_reg(REG_GAIN_X, 16'd1);
                    write_reg(REG_GAIN_Y, 16'hFFFF);
                    write_reg(REG_GAIN_Z, 16'd0);
                end
                default: begin
                    write_reg(REG_AXIS_ORDER, 16'($urandom_range(1)));
                    case ($urandom_range(2))
                        0: write_reg(REG_MIN_INTERVAL_US, 16'd0);
                        1: write_reg(REG_MIN_INTERVAL_US, 16'hFFFF);
                        default: write_reg(REG_MIN_INTERVAL_US, 16'($urandom_range(1, 20000)));
                    endcase
                    write_reg(REG_GAIN_X, pick_gain());
                    write_reg(REG_GAIN_Y, pick_gain());
                    write_reg(REG_GAIN_Z, pick_gain());
                end
            endcase
            run_sequences(phase == 2 ? 30 : PHASE_BEATS);
        end
        drain();
    endtask

    initial begin
        enabled_cfg = 1'b0;
        swap_yz_cfg = 1'b0;
        min_gap_cfg = MIN_INTERVAL_RST;
        gain_x_cfg = GAIN_RST;
        gain_y_cfg = GAIN_RST;
        gain_z_cfg = GAIN_RST;
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        held_count = '0;
        last_take_us = '0;
        link_ok = 1'b1;
        stamp_us = 32'hFFFF_F000;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_disabled();
        test_special_cases();
        test_halving();
        test_random_traffic();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
